@@ hw/rtl/cns_pkg.sv @@
// cns_pkg: constants, filter coefficients, sequencer states and saturation helpers
// for the colored noise shaper; used by colored_noise_shaper.sv, no other dependencies
package cns_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int STATE_BITS  = 32;
  localparam int FRAC        = 24;
  localparam int GAIN_W      = 16;
  localparam int GAIN_FRAC   = 14;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = GAIN_W;

  // white sample in q1.(SAMPLE_BITS-1) moved up to the q8.24 state grid
  localparam int WQ_SHIFT   = FRAC + 1 - SAMPLE_BITS;
  // y (q.24) times gain (q.14) back to the sample grid
  localparam int GAIN_SHIFT = FRAC + GAIN_FRAC + 1 - SAMPLE_BITS;

  // shared multiplier operand and result widths
  localparam int OPA_W  = STATE_BITS + 4;
  localparam int OPB_W  = 28;
  localparam int MUL_W  = OPA_W + OPB_W;
  localparam int PROD_W = STATE_BITS + 8;
  localparam int SUM_W  = STATE_BITS + 4;

  localparam int NUM_POLES  = 6;
  localparam int PINK_TERMS = NUM_POLES + 1;
  localparam int IDX_W      = 3;

  localparam logic [MODE_W-1:0] MODE_PINK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BROWN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MUTE = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_MAX   = 16'd32768;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

  // coefficients scaled by 2^24
  localparam logic signed [OPB_W-1:0] POLE_K [NUM_POLES] = '{
    28'sd16758090, 28'sd16665144, 28'sd16257122,
    28'sd14537458, 28'sd9227469,  -28'sd12777528
  };
  localparam logic signed [OPB_W-1:0] FEED_K [NUM_POLES] = '{
    28'sd931436,  28'sd1259565, 28'sd2581208,
    28'sd5209084, 28'sd8941454, -28'sd283501
  };
  localparam logic signed [OPB_W-1:0] K_DIRECT      = 28'sd8995943;
  localparam logic signed [OPB_W-1:0] K_DELAY       = 28'sd1944916;
  localparam logic signed [OPB_W-1:0] K_PINK_SCALE  = 28'sd1845494;
  localparam logic signed [OPB_W-1:0] K_BROWN_IN    = 28'sd335544;
  localparam logic signed [OPB_W-1:0] K_BROWN_RECIP = 28'sd16448251;
  localparam logic signed [OPB_W-1:0] K_BROWN_OUT   = 28'sd58720256;

  // rounding offsets, half an lsb of the result grid
  localparam logic signed [MUL_W-1:0] HALF_FRAC =
    {{(MUL_W - FRAC){1'b0}}, 1'b1, {(FRAC - 1){1'b0}}};
  localparam logic signed [MUL_W-1:0] HALF_GAIN =
    {{(MUL_W - GAIN_SHIFT){1'b0}}, 1'b1, {(GAIN_SHIFT - 1){1'b0}}};

  // brown level is held to plus or minus one
  localparam logic signed [PROD_W-1:0] BROWN_HI = PROD_W'(1) << FRAC;
  localparam logic signed [PROD_W-1:0] BROWN_LO = -BROWN_HI;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POLE,
    ST_FEED,
    ST_DIRECT,
    ST_DELAY,
    ST_SCALE,
    ST_BIN,
    ST_BSUM,
    ST_RECIP,
    ST_BSAT,
    ST_BOUT,
    ST_GAIN,
    ST_OUT
  } state_e;

  function automatic logic signed [STATE_BITS-1:0] sat_state(
    input logic signed [PROD_W:0] v
  );
    logic signed [PROD_W:0] hi;
    logic signed [PROD_W:0] lo;
    hi = {{(PROD_W - STATE_BITS + 2){1'b0}}, {(STATE_BITS - 1){1'b1}}};
    lo = {{(PROD_W - STATE_BITS + 2){1'b1}}, {(STATE_BITS - 1){1'b0}}};
    if (v > hi) begin
      sat_state = hi[STATE_BITS-1:0];
    end else if (v < lo) begin
      sat_state = lo[STATE_BITS-1:0];
    end else begin
      sat_state = v[STATE_BITS-1:0];
    end
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [PROD_W-1:0] v
  );
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = {{(PROD_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    lo = {{(PROD_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};
    if (v > hi) begin
      sat_sample = hi[SAMPLE_BITS-1:0];
    end else if (v < lo) begin
      sat_sample = lo[SAMPLE_BITS-1:0];
    end else begin
      sat_sample = v[SAMPLE_BITS-1:0];
    end
  endfunction

endpackage

@@ hw/rtl/colored_noise_shaper.sv @@
// colored_noise_shaper: white, pink or brown noise shaping with gain and saturation
// depends on cns_pkg
//
// One white sample in, one shaped sample out. All products go through a single
// signed 36x28 multiplier with a registered, rounded result, stepped by a small
// sequencer; the input stalls from acceptance until the result is loaded into the
// output register. Pink: two products per pole term for six terms, then direct,
// delay, scale, gain; brown: input, sum, reciprocal, saturate, output, gain;
// white: gain only; muted or zero gain: output only. Output waits while its
// register is held by a stalled earlier result. A mode write clears the filter
// state at once; configuration is expected only while idle.
module colored_noise_shaper import cns_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] white_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] out_sample_o,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i
);

  state_e state_q, state_d;

  logic [MODE_W-1:0]              mode_q;
  logic [GAIN_W-1:0]              gain_q;
  logic                           mute_q;
  logic signed [STATE_BITS-1:0]   pink_q [PINK_TERMS];
  logic signed [STATE_BITS-1:0]   brown_q;
  logic [IDX_W-1:0]               idx_q;
  logic                           out_valid_q;

  logic signed [SAMPLE_BITS-1:0]  samp_q;
  logic signed [SUM_W-1:0]        sum_q;
  logic signed [PROD_W-1:0]       acc_q;
  logic signed [PROD_W-1:0]       prod_q, prod_d;
  logic signed [SAMPLE_BITS-1:0]  out_q;

  logic signed [OPA_W-1:0]        opa;
  logic signed [OPB_W-1:0]        opb;
  logic                           is_gain;
  logic signed [MUL_W-1:0]        mul_p;
  logic signed [MUL_W-1:0]        mul_r;
  logic signed [MUL_W-1:0]        mul_sh;
  logic signed [PROD_W-1:0]       rnd;

  logic signed [OPA_W-1:0]        wq;
  logic signed [PROD_W:0]         term_sum;
  logic signed [STATE_BITS-1:0]   term_sat;
  logic signed [STATE_BITS-1:0]   prod_sat;
  logic signed [PROD_W-1:0]       brown_ext;
  logic signed [STATE_BITS-1:0]   pink_last;

  logic in_acc;
  logic out_load;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  assign wq = {{(OPA_W - SAMPLE_BITS - WQ_SHIFT){samp_q[SAMPLE_BITS-1]}},
               samp_q, {WQ_SHIFT{1'b0}}};

  // pole product plus feed product, saturated into the term
  assign term_sum  = {acc_q[PROD_W-1], acc_q} + {prod_q[PROD_W-1], prod_q};
  assign term_sat  = sat_state(term_sum);
  assign prod_sat  = sat_state({prod_q[PROD_W-1], prod_q});
  assign brown_ext = {{(PROD_W - STATE_BITS){brown_q[STATE_BITS-1]}}, brown_q};
  assign pink_last = pink_q[PINK_TERMS-1];

  // shared multiplier, round to nearest with ties up
  assign mul_p  = opa * opb;
  assign mul_r  = mul_p + (is_gain ? HALF_GAIN : HALF_FRAC);
  assign mul_sh = is_gain ? (mul_r >>> GAIN_SHIFT) : (mul_r >>> FRAC);
  assign rnd    = mul_sh[PROD_W-1:0];

  always_comb begin
    state_d = state_q;
    opa     = '0;
    opb     = '0;
    is_gain = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (mute_q || (gain_q == '0)) begin
            state_d = ST_OUT;
          end else begin
            unique case (mode_q)
              MODE_PINK:  state_d = ST_POLE;
              MODE_BROWN: state_d = ST_BIN;
              default:    state_d = ST_GAIN;
            endcase
          end
        end
      end
      ST_POLE: begin
        opa     = {{(OPA_W - STATE_BITS){pink_q[idx_q][STATE_BITS-1]}}, pink_q[idx_q]};
        opb     = POLE_K[idx_q];
        state_d = ST_FEED;
      end
      ST_FEED: begin
        opa     = wq;
        opb     = FEED_K[idx_q];
        state_d = (idx_q == IDX_W'(NUM_POLES - 1)) ? ST_DIRECT : ST_POLE;
      end
      ST_DIRECT: begin
        opa     = wq;
        opb     = K_DIRECT;
        state_d = ST_DELAY;
      end
      ST_DELAY: begin
        opa     = wq;
        opb     = K_DELAY;
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        opa     = sum_q;
        opb     = K_PINK_SCALE;
        state_d = ST_GAIN;
      end
      ST_BIN: begin
        opa     = wq;
        opb     = K_BROWN_IN;
        state_d = ST_BSUM;
      end
      ST_BSUM: begin
        state_d = ST_RECIP;
      end
      ST_RECIP: begin
        opa     = acc_q[OPA_W-1:0];
        opb     = K_BROWN_RECIP;
        state_d = ST_BSAT;
      end
      ST_BSAT: begin
        state_d = ST_BOUT;
      end
      ST_BOUT: begin
        opa     = acc_q[OPA_W-1:0];
        opb     = K_BROWN_OUT;
        state_d = ST_GAIN;
      end
      ST_GAIN: begin
        // shaped modes leave y in the product register
        opa     = ((mode_q == MODE_PINK) || (mode_q == MODE_BROWN)) ?
                  prod_q[OPA_W-1:0] : wq;
        opb     = {{(OPB_W - GAIN_W){1'b0}}, gain_q};
        is_gain = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (state_q == ST_IDLE) begin
      prod_d = '0;
    end else if (state_q == ST_OUT) begin
      prod_d = prod_q;
    end else begin
      prod_d = rnd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= '0;
      gain_q      <= GAIN_RESET;
      mute_q      <= 1'b0;
      brown_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < PINK_TERMS; i++) begin
        pink_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_MODE: begin
            mode_q  <= cfg_data_i[MODE_W-1:0];
            brown_q <= '0;
            for (int i = 0; i < PINK_TERMS; i++) begin
              pink_q[i] <= '0;
            end
          end
          REG_GAIN: gain_q <= (cfg_data_i > GAIN_MAX) ? GAIN_MAX : cfg_data_i;
          REG_MUTE: mute_q <= cfg_data_i[0];
          default: ;
        endcase
      end else begin
        if (in_acc) begin
          idx_q <= '0;
        end
        if (state_q == ST_FEED) begin
          idx_q <= idx_q + 1'b1;
        end
        // feed product of the previous term is in prod_q
        if (((state_q == ST_POLE) && (idx_q != '0)) || (state_q == ST_DIRECT)) begin
          pink_q[idx_q - 1'b1] <= term_sat;
        end
        if (state_q == ST_SCALE) begin
          pink_q[PINK_TERMS-1] <= prod_sat;
        end
        if (state_q == ST_BOUT) begin
          if (acc_q > BROWN_HI) begin
            brown_q <= BROWN_HI[STATE_BITS-1:0];
          end else if (acc_q < BROWN_LO) begin
            brown_q <= BROWN_LO[STATE_BITS-1:0];
          end else begin
            brown_q <= acc_q[STATE_BITS-1:0];
          end
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (in_acc) begin
      samp_q <= white_sample_i;
      sum_q  <= '0;
    end
    if (((state_q == ST_POLE) && (idx_q != '0)) || (state_q == ST_DIRECT)) begin
      sum_q <= sum_q + {{(SUM_W - STATE_BITS){term_sat[STATE_BITS-1]}}, term_sat};
    end
    if (state_q == ST_DELAY) begin
      sum_q <= sum_q + {{(SUM_W - STATE_BITS){pink_last[STATE_BITS-1]}}, pink_last}
               + prod_q[SUM_W-1:0];
    end
    if (state_q == ST_FEED) begin
      acc_q <= prod_q;
    end
    if (state_q == ST_BSUM) begin
      acc_q <= brown_ext + prod_q;
    end
    if (state_q == ST_BSAT) begin
      acc_q <= {{(PROD_W - STATE_BITS){prod_sat[STATE_BITS-1]}}, prod_sat};
    end
    if (out_load) begin
      out_q <= sat_sample(prod_q);
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_q;

endmodule
